// ===== src/hfd_pkg.sv =====
// Package: shared types and constants of the header frame deframer.
`timescale 1ns / 1ps

package hfd_pkg;

   localparam int HEADER_BYTES = 18;
   localparam int RSP_DEPTH    = 4;

   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_H    = 8'h48;
   localparam logic [7:0] CH_D    = 8'h44;

   typedef enum logic [2:0] {
      EV_PAYLOAD = 3'd0,
      EV_ACCEPT  = 3'd1,
      EV_WRONG   = 3'd2,
      EV_END     = 3'd3,
      EV_MISSING = 3'd4
   } event_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load;
      logic take_rx;
   } cell_ctl_type;

   // per-cell character flags
   typedef struct packed {
      logic bang;
      logic h;
   } cell_flags_type;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  payload;
      logic [31:0] source;
      logic [31:0] dest;
      logic [31:0] number;
   } result_type;

endpackage

// ===== src/hfd_cell.sv =====
// One byte cell of the window chain, with character flags.
`timescale 1ns / 1ps

module hfd_cell (
   input  logic                    clock,
   input  hfd_pkg::cell_ctl_type   ctl,
   input  logic [7:0]              neighbor,
   input  logic [7:0]              rx,
   output logic [7:0]              data,
   output hfd_pkg::cell_flags_type flags
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   assign data_in = ctl.take_rx ? rx : neighbor;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= data_in;
      end
   end

   assign data       = data_ff;
   assign flags.bang = (data_ff == hfd_pkg::CH_BANG);
   assign flags.h    = (data_ff == hfd_pkg::CH_H);

endmodule

// ===== src/hfd_rsp_fifo.sv =====
// Result queue: takes up to two items per cycle, delivers one while out_ready is high.
`timescale 1ns / 1ps

module hfd_rsp_fifo #(
   parameter int DEPTH = hfd_pkg::RSP_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_n,
   input  hfd_pkg::result_type push_d0,
   input  hfd_pkg::result_type push_d1,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output hfd_pkg::result_type out_d
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   hfd_pkg::result_type entries [DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign pop       = out_valid && out_ready;
   assign wr_next   = next_ptr(wr_ptr_ff);
   assign out_valid = (count_ff != '0);
   assign out_d     = entries[rd_ptr_ff];
   // worst case is two items in one cycle
   assign has_room  = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      count_in  = CW'(count_ff + CW'(push_n) - CW'(pop));
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case (push_n)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = next_ptr(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entries[wr_ptr_ff] <= push_d0;
      end
      if (push_n == 2'd2) begin
         entries[wr_next] <= push_d1;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue count out of range");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_n != 2'd0) |-> has_room)
      else $error("result pushed without room");
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

// ===== src/header_frame_deframer.sv =====
// Top level of the header frame deframer: cell chain, sequencer, result queue.
`timescale 1ns / 1ps

// Usage
//   req_*  : one received byte per item, req_buffer_last on the last byte of a buffer.
//   rsp_*  : result items (payload byte, header accepted, wrong address, frame end,
//            delimiter missing) with the fields of the current header.
//   csr_*  : write of own_address; always ready, write only while idle.
// Results: the results of an accepted item are registered in the result queue.
// Throughput: one item per cycle while req_ready is high. An item yields zero, one or
//   two results; the 18-byte window is a chain of byte cells shifted once per item
//   while searching, and the header compare works on the chain plus the incoming byte.
// Payload bytes leave through a two-byte delay line in the first two cells,
//   so the delimiter is never passed on.
// Stall: results go into a RSP_DEPTH entry queue; req_ready drops while fewer
//   than two entries are free, and comes back as soon as rsp_ready drains it.
// Reset: clears the window fill count, mode, held header fields, queue and
//   own_address. No clearing pass; the fill count gates the compare.
module header_frame_deframer #(
   parameter int RSP_DEPTH = hfd_pkg::RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_buffer_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_payload_byte,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_dest_address,
   output logic [31:0] rsp_packet_number,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_own_address
);

   localparam int NB = hfd_pkg::HEADER_BYTES;
   localparam int FW = $clog2(NB + 1);

   // control state
   logic [31:0]   own_address_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic          in_payload_ff, in_payload_in;
   logic [1:0]    held_count_ff, held_count_in;
   logic [31:0]   held_source_ff, held_source_in;
   logic [31:0]   held_dest_ff, held_dest_in;
   logic [31:0]   held_number_ff, held_number_in;

   // cell chain
   hfd_pkg::cell_ctl_type   ctl   [NB];
   hfd_pkg::cell_flags_type flags [NB];
   logic [7:0]              win   [NB];

   logic                step;
   logic                hdr_match;
   logic [31:0]         new_dest;
   logic                main_valid, miss;
   hfd_pkg::event_type  main_ev;
   logic [7:0]          main_pb;
   logic [1:0]          push_n;
   hfd_pkg::result_type push_d0, push_d1, out_d;
   logic                has_room;

   assign step      = req_valid && req_ready;
   assign req_ready = has_room;
   assign csr_ready = 1'b1;

   for (genvar i = 0; i < NB; i++) begin : g_cell
      logic [7:0] nb;
      if (i == NB - 1) begin : g_end
         assign nb = req_rx_byte;
      end else begin : g_mid
         assign nb = win[i+1];
      end
      hfd_cell u_cell (
         .clock    (clock),
         .ctl      (ctl[i]),
         .neighbor (nb),
         .rx       (req_rx_byte),
         .data     (win[i]),
         .flags    (flags[i])
      );
   end

   // Searching: every cell shifts toward index 0, last cell takes the byte.
   // Payload: cell 0/1 form the delay line, filled by held_count.
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         if (in_payload_ff) begin
            ctl[i].load    = step && ((i == 0 && held_count_ff != 2'd1) ||
                                      (i == 1 && held_count_ff != 2'd0));
            ctl[i].take_rx = (i == 1) || (i == 0 && held_count_ff == 2'd0);
         end else begin
            ctl[i].load    = step;
            ctl[i].take_rx = (i == NB - 1);
         end
      end
   end

   // header check on the shifted window: old cell k+1 is new index k
   assign hdr_match = (fill_ff >= FW'(NB - 1)) &&
                      flags[1].bang && flags[2].bang && flags[3].h &&
                      flags[16].bang && flags[17].bang &&
                      (req_rx_byte == hfd_pkg::CH_H);
   assign new_dest  = {win[11], win[10], win[9], win[8]};

   always_comb begin
      fill_in        = fill_ff;
      in_payload_in  = in_payload_ff;
      held_count_in  = held_count_ff;
      held_source_in = held_source_ff;
      held_dest_in   = held_dest_ff;
      held_number_in = held_number_ff;
      main_valid     = 1'b0;
      main_ev        = hfd_pkg::EV_PAYLOAD;
      main_pb        = 8'd0;
      miss           = 1'b0;
      if (step) begin
         if (in_payload_ff) begin
            if (held_count_ff == 2'd2) begin
               main_valid = 1'b1;
               if (flags[0].bang && flags[1].bang && req_rx_byte == hfd_pkg::CH_D) begin
                  // delimiter consumed, back to searching
                  main_ev       = hfd_pkg::EV_END;
                  in_payload_in = 1'b0;
                  held_count_in = 2'd0;
                  fill_in       = '0;
               end else begin
                  main_ev = hfd_pkg::EV_PAYLOAD;
                  main_pb = win[0];
               end
            end else begin
               held_count_in = held_count_ff + 2'd1;
            end
         end else begin
            if (fill_ff < FW'(NB)) begin
               fill_in = fill_ff + 1'b1;
            end
            if (hdr_match) begin
               main_valid     = 1'b1;
               held_source_in = {win[7], win[6], win[5], win[4]};
               held_dest_in   = new_dest;
               held_number_in = {win[15], win[14], win[13], win[12]};
               if (new_dest == own_address_ff) begin
                  main_ev       = hfd_pkg::EV_ACCEPT;
                  in_payload_in = 1'b1;
                  held_count_in = 2'd0;
                  fill_in       = '0;
               end else begin
                  main_ev = hfd_pkg::EV_WRONG;
               end
            end
         end
         // buffer end: no header spans buffers, open payload is cut off
         if (req_buffer_last) begin
            if (in_payload_in) begin
               miss = 1'b1;
            end
            in_payload_in = 1'b0;
            held_count_in = 2'd0;
            fill_in       = '0;
         end
      end
   end

   // queue inputs; a lone missing-delimiter item goes into slot 0
   always_comb begin
      push_d0.source  = held_source_in;
      push_d0.dest    = held_dest_in;
      push_d0.number  = held_number_in;
      push_d0.ev      = main_valid ? main_ev : hfd_pkg::EV_MISSING;
      push_d0.payload = main_valid ? main_pb : 8'd0;
      push_d1         = push_d0;
      push_d1.ev      = hfd_pkg::EV_MISSING;
      push_d1.payload = 8'd0;
      push_n          = 2'(main_valid) + 2'(miss);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         fill_ff        <= '0;
         in_payload_ff  <= 1'b0;
         held_count_ff  <= 2'd0;
         held_source_ff <= '0;
         held_dest_ff   <= '0;
         held_number_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            own_address_ff <= csr_own_address;
         end
         fill_ff        <= fill_in;
         in_payload_ff  <= in_payload_in;
         held_count_ff  <= held_count_in;
         held_source_ff <= held_source_in;
         held_dest_ff   <= held_dest_in;
         held_number_ff <= held_number_in;
      end
   end

   hfd_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_d0   (push_d0),
      .push_d1   (push_d1),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_d     (out_d)
   );

   assign rsp_event_res      = out_d.ev;
   assign rsp_payload_byte   = out_d.payload;
   assign rsp_source_address = out_d.source;
   assign rsp_dest_address   = out_d.dest;
   assign rsp_packet_number  = out_d.number;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(NB))
      else $error("window fill out of range");
   a_search_no_held: assert property (@(posedge clock) disable iff (reset)
      !in_payload_ff |-> (held_count_ff == 2'd0))
      else $error("delay line occupied while searching");
   a_last_ends_payload: assert property (@(posedge clock) disable iff (reset)
      (step && req_buffer_last) |=> (!in_payload_ff && fill_ff == '0))
      else $error("buffer end did not reset framing");
`endif

endmodule

// ===== test/header_frame_deframer_test.sv =====
// Testbench of the header frame deframer: random byte streams checked against a predictor.
`timescale 1ns / 1ps

module header_frame_deframer_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 330;
   localparam int IDLE_PCT    = 30;
   localparam int REPORT_MAX  = 10;

   // Tracks the deframer state and holds the events each received byte is due to cause.
   class deframe_tracker;
      logic [7:0]           window [hfd_pkg::HEADER_BYTES];
      int                   fill;
      bit                   in_payload;
      int                   held_count;
      logic [31:0]          held_source;
      logic [31:0]          held_dest;
      logic [31:0]          held_number;
      logic [31:0]          station;
      hfd_pkg::result_type  expected_events [$];
      int                   mismatches;

      function new();
         foreach (window[i]) window[i] = 8'h00;
         fill        = 0;
         in_payload  = 1'b0;
         held_count  = 0;
         held_source = '0;
         held_dest   = '0;
         held_number = '0;
         station     = '0;
         mismatches  = 0;
      endfunction

      function void set_station(logic [31:0] addr);
         station = addr;
      endfunction

      function void push_event(hfd_pkg::event_type ev, logic [7:0] pb);
         hfd_pkg::result_type r;
         r.ev      = ev;
         r.payload = pb;
         r.source  = held_source;
         r.dest    = held_dest;
         r.number  = held_number;
         expected_events.push_back(r);
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         int i;
         if (in_payload) begin
            // window[0..1] is the delay line; the delimiter never leaves it
            if (held_count >= 2 && window[0] == hfd_pkg::CH_BANG &&
                window[1] == hfd_pkg::CH_BANG && b == hfd_pkg::CH_D) begin
               push_event(hfd_pkg::EV_END, 8'h00);
               in_payload = 1'b0;
               held_count = 0;
               fill       = 0;
            end else if (held_count >= 2) begin
               push_event(hfd_pkg::EV_PAYLOAD, window[0]);
               window[0] = window[1];
               window[1] = b;
            end else begin
               window[held_count] = b;
               held_count++;
            end
         end else begin
            for (i = 0; i < hfd_pkg::HEADER_BYTES - 1; i++) window[i] = window[i + 1];
            window[hfd_pkg::HEADER_BYTES - 1] = b;
            if (fill < hfd_pkg::HEADER_BYTES) fill++;
            if (fill >= hfd_pkg::HEADER_BYTES &&
                window[0] == hfd_pkg::CH_BANG && window[1] == hfd_pkg::CH_BANG &&
                window[2] == hfd_pkg::CH_H && window[15] == hfd_pkg::CH_BANG &&
                window[16] == hfd_pkg::CH_BANG && window[17] == hfd_pkg::CH_H) begin
               held_source = {window[6], window[5], window[4], window[3]};
               held_dest   = {window[10], window[9], window[8], window[7]};
               held_number = {window[14], window[13], window[12], window[11]};
               if (held_dest == station) begin
                  push_event(hfd_pkg::EV_ACCEPT, 8'h00);
                  in_payload = 1'b1;
                  held_count = 0;
                  fill       = 0;
               end else begin
                  push_event(hfd_pkg::EV_WRONG, 8'h00);
               end
            end
         end
         // end of buffer: drop the delay line, restart the search
         if (last) begin
            if (in_payload) begin
               push_event(hfd_pkg::EV_MISSING, 8'h00);
               in_payload = 1'b0;
               held_count = 0;
            end
            fill = 0;
         end
      endfunction

      function void check_event(hfd_pkg::result_type got);
         hfd_pkg::result_type want;
         if (expected_events.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected event: ev=%0d pb=%02h src=%08h dst=%08h num=%08h",
                        got.ev, got.payload, got.source, got.dest, got.number);
            return;
         end
         want = expected_events.pop_front();
         if (got.ev !== want.ev || got.payload !== want.payload ||
             got.source !== want.source || got.dest !== want.dest ||
             got.number !== want.number) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display({"mismatch: expected ev=%0d pb=%02h src=%08h dst=%08h num=%08h,",
                         " got ev=%0d pb=%02h src=%08h dst=%08h num=%08h"},
                        want.ev, want.payload, want.source, want.dest, want.number,
                        got.ev, got.payload, got.source, got.dest, got.number);
         end
      endfunction

      function int outstanding();
         return expected_events.size();
      endfunction
   endclass

   typedef struct {
      logic [7:0] data;
      logic       last;
   } rx_item_type;

   // Every input driven to a known value from time zero
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte     = 8'h00;
   logic        req_buffer_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_payload_byte;
   logic [31:0] rsp_source_address;
   logic [31:0] rsp_dest_address;
   logic [31:0] rsp_packet_number;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_own_address = 32'h0;

   bit          req_steady = 1'b0;   // no gaps on the byte side
   bit          rsp_steady = 1'b0;   // no stalls on the event side
   logic [31:0] own_addr   = 32'h0;  // address the block currently holds
   int          cycle_count = 0;
   rx_item_type burst [$];           // bytes waiting to be sent
   deframe_tracker tracker = new();

   header_frame_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_buffer_last    (req_buffer_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_source_address (rsp_source_address),
      .rsp_dest_address   (rsp_dest_address),
      .rsp_packet_number  (rsp_packet_number),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_own_address    (csr_own_address)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("header_frame_deframer test failed");
      $finish;
   end

   // Event side stalls about 30% of cycles unless held steady
   always @(negedge clock) begin
      rsp_ready <= rsp_steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Sample all handshakes at the rising edge, before the block updates
   always @(posedge clock) begin : monitor
      hfd_pkg::result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.set_station(csr_own_address);
         if (rsp_valid && rsp_ready) begin
            got.ev      = hfd_pkg::event_type'(rsp_event_res);
            got.payload = rsp_payload_byte;
            got.source  = rsp_source_address;
            got.dest    = rsp_dest_address;
            got.number  = rsp_packet_number;
            tracker.check_event(got);
         end
         if (req_valid && req_ready) tracker.note_byte(req_rx_byte, req_buffer_last);
      end
   end

   // Bytes biased toward the framing characters so partial matches are common
   function logic [7:0] noise_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) return hfd_pkg::CH_BANG;
      if (pick < 35) return hfd_pkg::CH_H;
      if (pick < 45) return hfd_pkg::CH_D;
      return 8'($urandom);
   endfunction

   function logic [31:0] pick_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return 32'h0000_0000;
      if (pick < 20) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   function void push_byte(logic [7:0] b);
      rx_item_type it;
      it.data = b;
      it.last = 1'b0;
      burst.push_back(it);
   endfunction

   // '!!H', source, destination, number (little-endian), '!!H'
   function void push_header(logic [31:0] src, logic [31:0] dst, logic [31:0] num);
      int k;
      push_byte(hfd_pkg::CH_BANG);
      push_byte(hfd_pkg::CH_BANG);
      push_byte(hfd_pkg::CH_H);
      for (k = 0; k < 4; k++) push_byte(src[8*k +: 8]);
      for (k = 0; k < 4; k++) push_byte(dst[8*k +: 8]);
      for (k = 0; k < 4; k++) push_byte(num[8*k +: 8]);
      push_byte(hfd_pkg::CH_BANG);
      push_byte(hfd_pkg::CH_BANG);
      push_byte(hfd_pkg::CH_H);
   endfunction

   // One stretch of stimulus: mostly whole frames, some broken headers, some noise
   function void build_sequence();
      int          kind;
      int          len;
      int          k;
      int          last_pct;
      logic [31:0] dst;
      kind     = $urandom_range(99);
      last_pct = 35;
      if (kind < 65) begin
         repeat ($urandom_range(3)) push_byte(noise_byte());
         if ($urandom_range(99) < 80) dst = own_addr;
         else if ($urandom_range(1)) dst = own_addr ^ (32'h1 << $urandom_range(31));
         else dst = $urandom;
         push_header(pick_word(), dst, pick_word());
         if (dst == own_addr) begin
            len = ($urandom_range(99) < 10) ? $urandom_range(40) : $urandom_range(8);
            repeat (len) push_byte(noise_byte());
            if ($urandom_range(99) < 85) begin
               push_byte(hfd_pkg::CH_BANG);
               push_byte(hfd_pkg::CH_BANG);
               push_byte(hfd_pkg::CH_D);
            end else begin
               last_pct = 80;   // mostly cut the buffer inside the payload
            end
         end
      end else if (kind < 85) begin
         push_header(pick_word(), own_addr, pick_word());
         if ($urandom_range(1)) begin
            k = $urandom_range(17);
            burst[burst.size() - 1 - k].data = noise_byte();
         end else begin
            // header cut short by the end of the buffer
            repeat ($urandom_range(1, 17)) void'(burst.pop_back());
            last_pct = 100;
         end
      end else begin
         repeat ($urandom_range(1, 20)) push_byte(noise_byte());
      end
      if ($urandom_range(99) < last_pct) burst[burst.size() - 1].last = 1'b1;
   endfunction

   // Drive queued bytes; valid stays high between bytes unless a gap is drawn
   task send_burst();
      rx_item_type it;
      while (burst.size() != 0) begin
         it = burst.pop_front();
         if (!req_steady && $urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (!req_steady && $urandom_range(99) < IDLE_PCT);
         end
         req_valid       <= 1'b1;
         req_rx_byte     <= it.data;
         req_buffer_last <= it.last;
         do @(posedge clock); while (!req_ready);
         @(negedge clock);
      end
   endtask

   // Wait for every expected event, then wait on for bytes that cause none
   task settle();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task write_station(logic [31:0] addr);
      csr_valid       <= 1'b1;
      csr_own_address <= addr;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int phase;
      int sent;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme bytes ending a buffer, then a header matching the
      // reset address completed on the last byte (accept, then delimiter missing)
      push_byte(8'h00);
      push_byte(8'hFF);
      burst[burst.size() - 1].last = 1'b1;
      push_header(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      burst[burst.size() - 1].last = 1'b1;
      send_burst();
      settle();

      // Random phases, each under its own station address; phase 2 runs with no idling
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               own_addr = 32'hFFFF_FFFF;
            end
            2: begin
               own_addr = 32'h0000_0000;
            end
            4: begin
               own_addr = 32'h8000_0001;
            end
            default: begin
               own_addr = $urandom;
            end
         endcase
         write_station(own_addr);
         req_steady = (phase == 2);
         rsp_steady = (phase == 2);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            build_sequence();
            sent += burst.size();
            send_burst();
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("header_frame_deframer test passed");
      end else begin
         $display("header_frame_deframer test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/hfd_pkg.sv
src/hfd_cell.sv
src/hfd_rsp_fifo.sv
src/header_frame_deframer.sv
test/header_frame_deframer_test.sv
